@@ hdl/cce_pkg.sv @@
// Shared constants and types for the character CRC codeword encoder.
// Used by cce_cell and char_crc_codeword_encoder; depends on nothing else.
package cce_pkg;

    localparam int MSG_BITS      = 7;
    localparam int MAX_POLY_BITS = 33;
    localparam int REM_BITS      = MAX_POLY_BITS - 1;
    localparam int WORK_W        = MSG_BITS + REM_BITS;
    localparam int CW_W          = WORK_W;
    localparam int LEN_W         = 6;
    localparam int CFG_W         = MAX_POLY_BITS;
    localparam int SHAMT_W       = $clog2(REM_BITS + 1);

    // Configuration register indexes.
    localparam logic REG_GENERATOR = 1'b0;
    localparam logic REG_POLY_LEN  = 1'b1;

    // Data handed from one cell to the next.
    typedef struct packed {
        logic                valid;
        logic [MSG_BITS-1:0] msg;
        logic [WORK_W-1:0]   work;
    } t_cell_bus;

endpackage

@@ hdl/char_crc_codeword_encoder.sv @@
// Character CRC codeword encoder, top level: configuration, cell chain, output stage.
// Depends on cce_pkg and cce_cell.
// Pipeline: 7 registered cells, then 1 output stage, from an accepted transfer to its result strobe.
// Throughput: one character per cycle; busy is never raised and the receiver cannot stall.
// Reset: synchronous, active low; the generator returns to 11, the length to 4,
// and all in-flight transfers are dropped.
module char_crc_codeword_encoder
    import cce_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          i_data_char,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    output logic                o_valid,
    output logic [CW_W-1:0]     o_codeword,
    output logic [LEN_W-1:0]    o_codeword_length
);

    logic [MAX_POLY_BITS-1:0] r_gen;
    logic [LEN_W-1:0]         r_poly_len;
    logic [LEN_W-1:0]         len_clamped;
    logic [SHAMT_W-1:0]       rem_bits;
    logic [SHAMT_W-1:0]       align_shift;
    logic [MAX_POLY_BITS-1:0] gen_aligned;
    t_cell_bus                chain [MSG_BITS+1];
    logic [CW_W-1:0]          full_word;
    logic                     r_valid;
    logic [CW_W-1:0]          r_codeword;
    logic [LEN_W-1:0]         r_codeword_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen      <= MAX_POLY_BITS'(11);
            r_poly_len <= LEN_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GENERATOR: r_gen      <= i_cfg_wdata;
                REG_POLY_LEN:  r_poly_len <= i_cfg_wdata[LEN_W-1:0];
                default:       r_gen      <= r_gen;
            endcase
        end
    end

    always_comb begin
        len_clamped = r_poly_len;
        if (r_poly_len == '0) begin
            len_clamped = LEN_W'(1);
        end else if (r_poly_len > LEN_W'(MAX_POLY_BITS)) begin
            len_clamped = LEN_W'(MAX_POLY_BITS);
        end
    end

    assign rem_bits    = SHAMT_W'(len_clamped - LEN_W'(1));
    assign align_shift = SHAMT_W'(REM_BITS) - rem_bits;
    // Shifting left drops the pattern bits at and above its length.
    assign gen_aligned = r_gen << align_shift;

    assign busy = 1'b0;

    assign chain[0].valid = start;
    assign chain[0].msg   = i_data_char[MSG_BITS-1:0];
    assign chain[0].work  = {i_data_char[MSG_BITS-1:0], {REM_BITS{1'b0}}};

    for (genvar g = 0; g < MSG_BITS; g++) begin : g_cell
        cce_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_gen_aligned(gen_aligned),
            .i_bus        (chain[g]),
            .o_bus        (chain[g+1])
        );
    end

    // After all cells the remainder is left aligned in the top work bits.
    assign full_word = {chain[MSG_BITS].msg, chain[MSG_BITS].work[WORK_W-1 -: REM_BITS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chain[MSG_BITS].valid;
        end
        r_codeword        <= full_word >> align_shift;
        r_codeword_length <= LEN_W'(MSG_BITS) + LEN_W'(rem_bits);
    end

    assign o_valid           = r_valid;
    assign o_codeword        = r_codeword;
    assign o_codeword_length = r_codeword_length;

endmodule

@@ hdl/cce_cell.sv @@
// One division cell: handles the leading dividend bit and shifts the rest up.
// Depends on cce_pkg.
module cce_cell
    import cce_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [MAX_POLY_BITS-1:0] i_gen_aligned,
    input  t_cell_bus                i_bus,
    output t_cell_bus                o_bus
);

    logic                r_valid;
    logic [MSG_BITS-1:0] r_msg;
    logic [WORK_W-1:0]   r_work;
    logic [WORK_W-1:0]   n_work;
    logic [WORK_W-1:0]   gen_top;

    // The pattern's top bit sits on the leading work bit.
    assign gen_top = {i_gen_aligned, {(WORK_W - MAX_POLY_BITS){1'b0}}};

    always_comb begin
        n_work = i_bus.work;
        if (i_bus.work[WORK_W-1]) begin
            n_work = i_bus.work ^ gen_top;
        end
        n_work = {n_work[WORK_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
        r_msg  <= i_bus.msg;
        r_work <= n_work;
    end

    assign o_bus.valid = r_valid;
    assign o_bus.msg   = r_msg;
    assign o_bus.work  = r_work;

endmodule

@@ tb/sv/tb_char_crc_codeword_encoder.sv @@
// Self-checking testbench for the character CRC codeword encoder.
// Uses cce_pkg for widths and register indexes, and needs only the RTL under hdl/.
// A built-in predictor does the modulo-2 division and checks every codeword in order.
module tb_char_crc_codeword_encoder;
    timeunit 1ns;
    timeprecision 1ps;
    import cce_pkg::*;

    typedef struct {
        logic [CW_W-1:0]  cw;
        logic [LEN_W-1:0] len;
    } t_codeword;

    // Holds the expected codewords in order and a private copy of the two registers.
    class crc_codeword_tracker;
        logic [CFG_W-1:0] gen_bits;
        logic [LEN_W-1:0] poly_len;
        t_codeword        pending_codewords[$];
        int unsigned      errors;
        int unsigned      chars_seen;

        function new();
            gen_bits   = CFG_W'(11);
            poly_len   = LEN_W'(4);
            errors     = 0;
            chars_seen = 0;
        endfunction

        function t_codeword divide_char(input logic [7:0] ch);
            int unsigned n, rb, total;
            logic [63:0] msg, g, dv, tmp;
            t_codeword   r;
            n = poly_len;
            if (n < 1) n = 1;
            if (n > MAX_POLY_BITS) n = MAX_POLY_BITS;
            rb    = n - 1;
            total = MSG_BITS + rb;
            msg   = 64'(ch[MSG_BITS-1:0]);
            g     = 64'(gen_bits) & ((64'd1 << n) - 64'd1);
            dv    = msg << rb;
            // The pattern goes in at each 1 in the top MSG_BITS places, leading bit or not.
            for (int i = 0; i < MSG_BITS; i++) begin
                if (dv[total-1-i]) dv = dv ^ (g << (MSG_BITS - 1 - i));
            end
            tmp   = (msg << rb) | (dv & ((64'd1 << rb) - 64'd1));
            r.cw  = tmp[CW_W-1:0];
            r.len = total[LEN_W-1:0];
            return r;
        endfunction

        function void note_char(input logic [7:0] ch);
            pending_codewords.push_back(divide_char(ch));
            chars_seen++;
        endfunction

        function void check_codeword(input logic [CW_W-1:0] cw, input logic [LEN_W-1:0] len);
            t_codeword e;
            if (pending_codewords.size() == 0) begin
                $display("%0t: unexpected codeword %h length %0d", $time, cw, len);
                errors++;
                return;
            end
            e = pending_codewords.pop_front();
            if (cw !== e.cw) begin
                $display("%0t: codeword expected %h actual %h", $time, e.cw, cw);
                errors++;
            end
            if (len !== e.len) begin
                $display("%0t: codeword_length expected %0d actual %0d", $time, e.len, len);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_codewords.size();
        endfunction

        function void report_leftover();
            if (pending_codewords.size() != 0) begin
                $display("%0t: %0d codewords never arrived", $time, pending_codewords.size());
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [7:0]         i_data_char;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               o_valid;
    logic [CW_W-1:0]    o_codeword;
    logic [LEN_W-1:0]   o_codeword_length;

    crc_codeword_tracker tracker;
    int unsigned         settings_run;

    char_crc_codeword_encoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_data_char       (i_data_char),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .o_codeword        (o_codeword),
        .o_codeword_length (o_codeword_length)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) tracker.check_codeword(o_codeword, o_codeword_length);
    end

    // Presents one character; start stays high afterwards so back-to-back transfers
    // are possible.
    task automatic send_char(input logic [7:0] ch, input bit allow_idle);
        @(negedge i_clk);
        while (allow_idle && $urandom_range(0, 99) < 8) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_data_char <= ch;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        tracker.note_char(ch);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_GENERATOR) tracker.gen_bits = value;
        else tracker.poly_len = value[LEN_W-1:0];
    endtask

    // Upper bits of the length write are random; only the low six bits count.
    task automatic set_config(input logic [CFG_W-1:0] gen, input logic [LEN_W-1:0] plen);
        logic [CFG_W-1:0] word;
        word = {1'($urandom_range(0, 1)), $urandom()};
        word[LEN_W-1:0] = plen;
        drain();
        write_reg(REG_GENERATOR, gen);
        write_reg(REG_POLY_LEN, word);
        settings_run++;
    endtask

    task automatic random_chars(input int unsigned count, input bit allow_idle);
        repeat (count) send_char(8'($urandom_range(0, 255)), allow_idle);
    endtask

    initial begin
        logic [7:0]       directed_chars[8];
        logic [CFG_W-1:0] gen;
        logic [LEN_W-1:0] plen;

        start        = 1'b0;
        i_data_char  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_GENERATOR;
        i_cfg_wdata  = '0;
        i_rst_n      = 1'b0;
        settings_run = 1;
        tracker      = new();
        directed_chars = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h40};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings first, then the corner settings with a couple of characters each.
        foreach (directed_chars[k]) send_char(directed_chars[k], 1'b1);
        set_config({1'($urandom_range(0, 1)), $urandom()}, 6'd1);
        send_char(8'h7F, 1'b0);
        send_char(8'hC3, 1'b0);
        set_config({CFG_W{1'b1}}, 6'd0);
        send_char(8'h7F, 1'b0);
        send_char(8'h2A, 1'b0);
        set_config({CFG_W{1'b1}}, 6'd33);
        send_char(8'h7F, 1'b0);
        send_char(8'h81, 1'b0);
        set_config({CFG_W{1'b1}}, 6'd63);
        send_char(8'hFF, 1'b0);
        send_char(8'h40, 1'b0);
        set_config('0, 6'd2);
        send_char(8'h7F, 1'b0);
        send_char(8'h15, 1'b0);
        // Leading bit of the pattern is zero here, so later dividend bits still get flipped.
        set_config(CFG_W'(33'h35), 6'd8);
        send_char(8'h7F, 1'b0);
        send_char(8'hE9, 1'b0);

        for (int p = 0; p < 12; p++) begin
            gen = {1'($urandom_range(0, 1)), $urandom()};
            if ($urandom_range(0, 3) == 0) plen = 6'($urandom_range(0, 63));
            else plen = 6'($urandom_range(1, 33));
            set_config(gen, plen);
            random_chars(60, !(p == 3 || p == 8));
        end

        drain();
        repeat (12) @(posedge i_clk);
        tracker.report_leftover();
        $display("Encoded %0d characters under %0d generator settings,", tracker.chars_seen,
                 settings_run);
        $display("including zero, full and saturated pattern lengths.");
        if (tracker.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("%0t: run did not finish in time", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
